@@ design/btint_pkg.sv @@
// ============================================================================
// btint_pkg - shared types and constants of the bilinear table interpolator
// Field widths, operation and register codes, and the tag that travels with
// each corner word down the read and multiply pipeline.
// ============================================================================
package btint_pkg;

   // fixed field widths of the ports
   localparam int COORD_W     = 16;
   localparam int VALUE_W     = 16;
   localparam int ORIGIN_W    = 8;
   localparam int LAST_W      = 6;
   localparam int ENTRY_IDX_W = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // corners of one cell, read in order 0..3 (bit 1 = next row, bit 0 = next column)
   localparam logic [1:0] CORNER_LAST = 2'd3;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_ORIGIN = 2'd0,
      CSR_COL_ORIGIN = 2'd1,
      CSR_LAST_ROW   = 2'd2,
      CSR_LAST_COL   = 2'd3
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [ORIGIN_W-1:0] ROW_ORIGIN_RST = 8'd40;
   localparam logic [ORIGIN_W-1:0] COL_ORIGIN_RST = 8'd20;
   localparam logic [LAST_W-1:0]   LAST_ROW_RST   = 6'd40;
   localparam logic [LAST_W-1:0]   LAST_COL_RST   = 6'd40;

   // control tag of one corner word in flight
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic clamp;
   } tag_type;

endpackage

@@ design/bilinear_table_interpolator_core.sv @@
// ============================================================================
// bilinear_table_interpolator_core - grid lookup with bilinear interpolation
// Holds a GRID_ROWS x GRID_COLS surface of 16-bit entries in one dual-port
// memory. Write words load single entries; query words are located on the
// grid and their four cell corners are weighted and summed.
// ============================================================================
//
//   channel   direction   handshake            payload
//   -------   ---------   ------------------   --------------------------------
//   req_      in          req_valid/req_ready  op, temperature, load,
//                                              entry_row, entry_col, entry_value
//   rsp_      out         rsp_valid/rsp_ready  value, clamped
//   csr_      in          csr_write_en         csr_index, csr_wdata
//
// A write word writes the memory at its acceptance edge. A query word reads
// the memory read port once per corner, and no new word is accepted until
// the last corner of its cell issues. Reset clears all control state and
// loads the register defaults; the memory is not cleared. The result
// register parts the two sides: the pipeline stalls only when a finished
// result meets a full, untaken output register.
//
// Pipeline per corner: issue (address and weight) -> memory read / weight
// register -> product register -> accumulate into the output register.

module bilinear_table_interpolator_core #(
   parameter int GRID_ROWS = 64,
   parameter int GRID_COLS = 64,
   parameter int FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [0:0]                          req_op,
   input  logic [btint_pkg::COORD_W-1:0]       req_temperature,
   input  logic [btint_pkg::COORD_W-1:0]       req_load,
   input  logic [btint_pkg::ENTRY_IDX_W-1:0]   req_entry_row,
   input  logic [btint_pkg::ENTRY_IDX_W-1:0]   req_entry_col,
   input  logic [btint_pkg::VALUE_W-1:0]       req_entry_value,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [btint_pkg::VALUE_W-1:0]       rsp_value,
   output logic                                rsp_clamped,

   input  logic                                csr_write_en,
   input  logic [btint_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [btint_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH = GRID_ROWS * GRID_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RIW   = $clog2(GRID_ROWS);
   localparam int CIW   = $clog2(GRID_COLS);
   localparam int IXW   = (RIW > CIW) ? RIW : CIW;
   // room for the coordinate, the shifted origin and the shifted last index
   localparam int XW    = ((btint_pkg::ORIGIN_W + FRAC_BITS > btint_pkg::COORD_W) ?
                           btint_pkg::ORIGIN_W + FRAC_BITS : btint_pkg::COORD_W) + 2;
   localparam int FW    = FRAC_BITS + 1;          // fraction 0..ONE
   localparam int WW    = 2 * FRAC_BITS + 1;      // corner weight 0..ONE*ONE
   localparam int ACW   = btint_pkg::VALUE_W + 2 * FRAC_BITS;

   localparam logic [FW-1:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [8:0]    ROW_MAX = 9'(GRID_ROWS - 1);
   localparam logic [8:0]    COL_MAX = 9'(GRID_COLS - 1);

   typedef struct packed {
      logic [IXW-1:0] idx;
      logic [FW-1:0]  frac;
      logic           clamp;
   } loc_type;

   // Map one coordinate to a cell index and a fraction, clamping to the grid.
   function automatic loc_type locate(
      input logic [btint_pkg::COORD_W-1:0]  coord,
      input logic [btint_pkg::ORIGIN_W-1:0] origin,
      input logic [btint_pkg::LAST_W-1:0]   last_reg,
      input logic [8:0]                     last_max
   );
      logic [8:0]    last_eff;
      logic [XW-1:0] base;
      logic [XW-1:0] cext;
      logic [XW-1:0] rel;
      logic [XW-1:0] lim;
      loc_type       res;
      last_eff = 9'(last_reg);
      if (last_eff == 9'd0) begin
         last_eff = 9'd1;
      end
      if (last_eff > last_max) begin
         last_eff = last_max;
      end
      base = XW'(origin) << FRAC_BITS;
      cext = XW'(coord);
      lim  = XW'(last_eff) << FRAC_BITS;
      rel  = cext - base;
      if (cext < base) begin
         res.idx   = '0;
         res.frac  = '0;
         res.clamp = 1'b1;
      end else if (rel >= lim) begin
         res.idx   = IXW'(last_eff - 9'd1);
         res.frac  = ONE_FX;
         res.clamp = (rel != lim);
      end else begin
         res.idx   = rel[FRAC_BITS +: IXW];
         res.frac  = {1'b0, rel[FRAC_BITS-1:0]};
         res.clamp = 1'b0;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [btint_pkg::ORIGIN_W-1:0] row_origin_ff;
   logic [btint_pkg::ORIGIN_W-1:0] col_origin_ff;
   logic [btint_pkg::LAST_W-1:0]   last_row_ff;
   logic [btint_pkg::LAST_W-1:0]   last_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_origin_ff <= btint_pkg::ROW_ORIGIN_RST;
         col_origin_ff <= btint_pkg::COL_ORIGIN_RST;
         last_row_ff   <= btint_pkg::LAST_ROW_RST;
         last_col_ff   <= btint_pkg::LAST_COL_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            btint_pkg::CSR_ROW_ORIGIN: row_origin_ff <= csr_wdata;
            btint_pkg::CSR_COL_ORIGIN: col_origin_ff <= csr_wdata;
            btint_pkg::CSR_LAST_ROW:   last_row_ff   <= csr_wdata[btint_pkg::LAST_W-1:0];
            btint_pkg::CSR_LAST_COL:   last_col_ff   <= csr_wdata[btint_pkg::LAST_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stall and acceptance
   // ------------------------------------------------------------------
   logic                 adv;
   logic                 req_fire;
   logic                 query_fire;
   logic                 write_fire;

   logic                 iss_valid_ff, iss_valid_in;
   logic [1:0]           iss_cnt_ff, iss_cnt_in;
   logic [RIW-1:0]       iss_row_ff, iss_row_in;
   logic [CIW-1:0]       iss_col_ff, iss_col_in;
   logic [FW-1:0]        iss_fr_ff, iss_fr_in;
   logic [FW-1:0]        iss_fc_ff, iss_fc_in;
   logic                 iss_clamp_ff, iss_clamp_in;

   btint_pkg::tag_type   s1_tag_ff, s1_tag_in;
   btint_pkg::tag_type   s2_tag_ff, s2_tag_in;
   logic [WW-1:0]        weight_ff, weight_in;
   logic [btint_pkg::VALUE_W-1:0] rd_data_ff;
   logic [ACW-1:0]       prod_ff, prod_in;
   logic [ACW-1:0]       acc_ff, acc_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [btint_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_clamped_ff, rsp_clamped_in;

   loc_type              loc_r;
   loc_type              loc_c;

   // hold everything only when a finished sum meets a full, untaken output
   assign adv = !(rsp_valid_ff && !rsp_ready && s2_tag_ff.valid && s2_tag_ff.last);

   // the read port is busy until the last corner of the current cell issues
   assign req_ready  = adv && (!iss_valid_ff || (iss_cnt_ff == btint_pkg::CORNER_LAST));
   assign req_fire   = req_valid && req_ready;
   assign query_fire = req_fire && (req_op == btint_pkg::OP_QUERY);
   assign write_fire = req_fire && (req_op == btint_pkg::OP_WRITE);

   // ------------------------------------------------------------------
   // locate the query and load the issue stage
   // ------------------------------------------------------------------
   always_comb begin
      loc_r = locate(req_temperature, row_origin_ff, last_row_ff, ROW_MAX);
      loc_c = locate(req_load, col_origin_ff, last_col_ff, COL_MAX);

      iss_valid_in = iss_valid_ff;
      iss_cnt_in   = iss_cnt_ff;
      iss_row_in   = iss_row_ff;
      iss_col_in   = iss_col_ff;
      iss_fr_in    = iss_fr_ff;
      iss_fc_in    = iss_fc_ff;
      iss_clamp_in = iss_clamp_ff;

      if (adv && iss_valid_ff) begin
         iss_cnt_in = iss_cnt_ff + 2'd1;
         if (iss_cnt_ff == btint_pkg::CORNER_LAST) begin
            iss_valid_in = 1'b0;
         end
      end
      if (query_fire) begin
         iss_valid_in = 1'b1;
         iss_cnt_in   = '0;
         iss_row_in   = loc_r.idx[RIW-1:0];
         iss_col_in   = loc_c.idx[CIW-1:0];
         iss_fr_in    = loc_r.frac;
         iss_fc_in    = loc_c.frac;
         iss_clamp_in = loc_r.clamp | loc_c.clamp;
      end
   end

   // ------------------------------------------------------------------
   // corner address and weight
   // ------------------------------------------------------------------
   logic [RIW-1:0] row_sel;
   logic [CIW-1:0] col_sel;
   logic [FW-1:0]  wr_sel;
   logic [FW-1:0]  wc_sel;
   logic [AW-1:0]  rd_addr;
   logic [AW-1:0]  wr_addr;
   logic           wr_in_grid;

   always_comb begin
      row_sel = iss_row_ff + RIW'(iss_cnt_ff[1]);
      col_sel = iss_col_ff + CIW'(iss_cnt_ff[0]);
      wr_sel  = iss_cnt_ff[1] ? iss_fr_ff : (ONE_FX - iss_fr_ff);
      wc_sel  = iss_cnt_ff[0] ? iss_fc_ff : (ONE_FX - iss_fc_ff);
      weight_in = WW'(wr_sel) * WW'(wc_sel);
      rd_addr = AW'(row_sel) * AW'(GRID_COLS) + AW'(col_sel);

      s1_tag_in.valid = iss_valid_ff;
      s1_tag_in.first = (iss_cnt_ff == 2'd0);
      s1_tag_in.last  = (iss_cnt_ff == btint_pkg::CORNER_LAST);
      s1_tag_in.clamp = iss_clamp_ff;
   end

   // writes off the table are dropped
   assign wr_in_grid = (9'(req_entry_row) < 9'(GRID_ROWS)) &&
                       (9'(req_entry_col) < 9'(GRID_COLS));
   assign wr_addr    = AW'(req_entry_row) * AW'(GRID_COLS) + AW'(req_entry_col);

   // ------------------------------------------------------------------
   // surface memory: one write port, one registered read port
   // ------------------------------------------------------------------
   logic [btint_pkg::VALUE_W-1:0] surface_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_fire && wr_in_grid) begin
         surface_mem[wr_addr] <= req_entry_value;
      end
      if (adv && iss_valid_ff) begin
         rd_data_ff <= surface_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------
   // multiply and accumulate
   // ------------------------------------------------------------------
   logic [ACW-1:0] acc_sum;

   always_comb begin
      prod_in   = ACW'(rd_data_ff) * ACW'(weight_ff);
      s2_tag_in = s1_tag_ff;
      acc_sum   = (s2_tag_ff.first ? '0 : acc_ff) + prod_ff;
      acc_in    = acc_ff;
      if (adv && s2_tag_ff.valid) begin
         acc_in = acc_sum;
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_clamped_in = rsp_clamped_ff;
      if (adv && s2_tag_ff.valid && s2_tag_ff.last) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = acc_sum[2*FRAC_BITS +: btint_pkg::VALUE_W];
         rsp_clamped_in = s2_tag_ff.clamp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
         iss_cnt_ff   <= '0;
         s1_tag_ff    <= '0;
         s2_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         iss_valid_ff <= iss_valid_in;
         iss_cnt_ff   <= iss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            s1_tag_ff <= s1_tag_in;
            s2_tag_ff <= s2_tag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      iss_row_ff     <= iss_row_in;
      iss_col_ff     <= iss_col_in;
      iss_fr_ff      <= iss_fr_in;
      iss_fc_ff      <= iss_fc_in;
      iss_clamp_ff   <= iss_clamp_in;
      acc_ff         <= acc_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_clamped_ff <= rsp_clamped_in;
      if (adv) begin
         weight_ff <= weight_in;
         prod_ff   <= prod_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_clamped = rsp_clamped_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_no_accept_mid_cell: assert property (@(posedge clock) disable iff (reset)
      (iss_valid_ff && (iss_cnt_ff != btint_pkg::CORNER_LAST)) |-> !req_ready)
      else $error("word accepted while corner reads of a cell are pending");

   a_sum_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (adv && s2_tag_ff.valid && s2_tag_ff.last) |=> rsp_valid_ff)
      else $error("finished sum did not reach the output register");

   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      (s1_tag_ff.valid && s1_tag_ff.first) |-> !(s2_tag_ff.valid && !s2_tag_ff.last))
      else $error("first corner follows an unfinished cell");

   a_clamp_per_cell: assert property (@(posedge clock) disable iff (reset)
      (s1_tag_ff.valid && s2_tag_ff.valid && !s1_tag_ff.first) |->
      (s1_tag_ff.clamp == s2_tag_ff.clamp))
      else $error("clamp flag changed within one cell");

endmodule
